// File: sv/percent_decoder_defines.svh
// Assertion macros shared by the percent decoder RTL.
`ifndef PERCENT_DECODER_DEFINES_SVH
`define PERCENT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCTDEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCTDEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/pctdec_pkg.sv
package pctdec_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_QUERY   = 8'h3F;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // Nibble value of a hex digit; values at or above this mark a non-digit.
   localparam logic [4:0] HEX_BASE          = 5'd16;
   localparam logic [4:0] HEX_LETTER_OFFSET = 5'd10;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PERCENT = 2'd1,
      PH_HIGH    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_MISSING   = 2'd1,
      ERR_BAD_DIGIT = 2'd2
   } err_type;

   typedef struct packed {
      phase_type   phase;
      logic        query_seen;
      logic [7:0]  held_high_digit;
      logic        discarding;
   } state_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      err_type     error_code;
      logic        string_done;
   } result_type;

   // Returns 0..15 for a hex digit in either case, HEX_BASE otherwise.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      begin
         if (b >= 8'h30 && b <= 8'h39) begin
            v = 5'(b - 8'h30);
         end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 5'(b - 8'h41) + HEX_LETTER_OFFSET;
         end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 5'(b - 8'h61) + HEX_LETTER_OFFSET;
         end else begin
            v = HEX_BASE;
         end
         return v;
      end
   endfunction

endpackage

// File: sv/percent_decoder.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_in_byte, req_last_byte
// rsp      out        rsp_valid/rsp_ready    rsp_out_byte, rsp_error_code,
//                                            rsp_string_done
// csr      in         csr_valid/csr_ready    csr_plus_as_space
//
// An accepted byte is held in the input register and is decoded from there
// into the result register when it advances, which a stalled result can
// delay. One byte per cycle is sustained while the result side keeps up.
// Reset is synchronous, active high, and clears the string state, the
// plus-as-space mode and both valid flags. A stalled result holds up the
// input register only when that register's byte would produce a result.
`include "percent_decoder_defines.svh"

module percent_decoder import pctdec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_error_code,
   output logic       rsp_string_done,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_plus_as_space
);

   // Configuration: the mode register takes a transfer in any cycle.
   logic plus_as_space_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plus_as_space_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         plus_as_space_ff <= csr_plus_as_space;
      end
   end

   // Input register.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // String state and the decode step.
   state_type  state_ff;
   state_type  state_in;
   logic       emit;
   result_type result_in;
   logic       advance;

   // Result register.
   logic       out_valid_ff;
   result_type out_ff;

   pctdec_decode u_decode (
      .cur_state     (state_ff),
      .in_byte       (in_byte_ff),
      .last_byte     (in_last_ff),
      .plus_as_space (plus_as_space_ff),
      .nxt_state     (state_in),
      .emit          (emit),
      .result        (result_in)
   );

   // The held byte moves on when it makes no result, or when the result
   // register is empty or being emptied in this cycle.
   assign advance   = in_valid_ff && (!emit || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // The string state steps once for every byte that leaves the input
   // register, whether or not that byte makes a result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, query_seen: 1'b0,
                       held_high_digit: 8'd0, discarding: 1'b0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_ff <= result_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_ff.out_byte;
   assign rsp_error_code  = out_ff.error_code;
   assign rsp_string_done = out_ff.string_done;

   // An error result carries a zero byte and always closes the string.
   `PCTDEC_ASSERT_NOW(a_err_result_form, clock, reset,
      rsp_valid && (out_ff.error_code != ERR_NONE),
      (out_ff.out_byte == 8'd0) && out_ff.string_done,
      "error result with nonzero byte or without string_done")

   // Bytes dropped after an error never make a result.
   `PCTDEC_ASSERT_NOW(a_discard_silent, clock, reset,
      in_valid_ff && state_ff.discarding,
      !emit,
      "result produced while discarding")

   // The final byte of a string leaves the state clean for the next one.
   `PCTDEC_ASSERT_NEXT(a_end_clears, clock, reset,
      advance && in_last_ff,
      (state_ff.phase == PH_IDLE) && !state_ff.query_seen && !state_ff.discarding,
      "string state not cleared after final byte")

endmodule

// File: sv/pctdec_decode.sv
module pctdec_decode import pctdec_pkg::*; (
   input  state_type  cur_state,
   input  logic [7:0] in_byte,
   input  logic       last_byte,
   input  logic       plus_as_space,
   output state_type  nxt_state,
   output logic       emit,
   output result_type result
);

   logic [4:0] hi_val;
   logic [4:0] lo_val;
   logic       query_now;
   logic [7:0] val;
   err_type    err;

   assign hi_val    = hex_value(cur_state.held_high_digit);
   assign lo_val    = hex_value(in_byte);
   assign query_now = cur_state.query_seen || (in_byte == CH_QUERY);

   always_comb begin
      nxt_state = cur_state;
      emit      = 1'b0;
      err       = ERR_NONE;
      val       = 8'd0;

      if (!cur_state.discarding) begin
         unique case (cur_state.phase)
            PH_PERCENT: begin
               nxt_state.held_high_digit = in_byte;
               nxt_state.phase           = PH_HIGH;
               if (last_byte) begin
                  err  = ERR_MISSING;
                  emit = 1'b1;
               end
            end
            PH_HIGH: begin
               nxt_state.phase = PH_IDLE;
               emit            = 1'b1;
               if (hi_val[4] || lo_val[4]) begin
                  err = ERR_BAD_DIGIT;
               end else begin
                  val = {hi_val[3:0], lo_val[3:0]};
               end
            end
            default: begin
               // Idle, and the unreachable fourth phase code.
               nxt_state.phase      = PH_IDLE;
               nxt_state.query_seen = query_now;
               if (query_now && plus_as_space && in_byte == CH_PLUS) begin
                  val  = CH_SPACE;
                  emit = 1'b1;
               end else if (in_byte == CH_PERCENT) begin
                  nxt_state.phase = PH_PERCENT;
                  if (last_byte) begin
                     err  = ERR_MISSING;
                     emit = 1'b1;
                  end
               end else begin
                  val  = in_byte;
                  emit = 1'b1;
               end
            end
         endcase
      end

      if (last_byte) begin
         nxt_state.phase      = PH_IDLE;
         nxt_state.query_seen = 1'b0;
         nxt_state.discarding = 1'b0;
      end else if (err != ERR_NONE) begin
         nxt_state.phase      = PH_IDLE;
         nxt_state.discarding = 1'b1;
      end

      result.out_byte    = (err != ERR_NONE) ? 8'd0 : val;
      result.error_code  = err;
      result.string_done = last_byte || (err != ERR_NONE);
   end

endmodule

// File: test/tb.sv
module tb;
   import pctdec_pkg::*;

   // Run sizing. The random part stops once the byte count reaches TOTAL_BYTES.
   localparam int TOTAL_BYTES  = 1950;
   localparam int RAND_PHASES  = 6;
   // A byte that yields no result can still be in the pipe when the last
   // result shows up, so the driver waits this many idle cycles before it
   // writes the register or resumes after a hold.
   localparam int SETTLE       = 6;
   localparam int TAIL_CYCLES  = 12;
   // Near the end of the job list both sides stop idling.
   localparam int TAIL_JOBS    = 150;
   localparam int CYCLE_LIMIT  = 400000;

   // What one entry of the driver's job list asks for.
   typedef enum logic [1:0] {
      JOB_BYTE,   // one byte on the req channel
      JOB_CSR,    // one write of the plus-as-space register
      JOB_HOLD    // stop sending until every expected result has come
   } job_kind_type;

   typedef struct {
      job_kind_type kind;
      logic [7:0]   data;
      logic         last;
   } job_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_error_code;
   logic       rsp_string_done;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_plus_as_space = 1'b0;

   percent_decoder uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_error_code    (rsp_error_code),
      .rsp_string_done   (rsp_string_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_plus_as_space (csr_plus_as_space)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Jobs waiting for the driver, filled once at time zero.
   job_type    job_q[$];
   int         bytes_queued = 0;

   // Decoded results that the block still owes, oldest first.
   result_type want_q[$];
   // Copy of want_q.size() as of the last edge. It is updated with a
   // nonblocking assignment so that the driver and the end check read a
   // value that does not depend on which always block runs first.
   int         results_pending = 0;
   int         mismatches = 0;

   // Our own copy of the decoder state and of the register.
   phase_type  esc_phase = PH_IDLE;
   logic       in_query = 1'b0;
   logic [7:0] high_digit = 8'h00;
   logic       dropping = 1'b0;
   logic       cfg_plus_space = 1'b0;

   // Driver and sink bookkeeping.
   int         quiet = 0;
   int         gap_left = 0;
   int         gap_pct = 20;
   int         stall_left = 0;
   int         stall_pct = 20;
   logic       calm_tail = 1'b0;
   logic       stimulus_done = 1'b0;
   int         cycle_count = 0;

   // Value of one hex digit in either case; HEX_BASE for anything else.
   function automatic logic [4:0] digit_weight(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b0, 4'(c - "0")};
      end
      if (c >= "A" && c <= "F") begin
         return {1'b0, 4'(c - "A" + 8'd10)};
      end
      if (c >= "a" && c <= "f") begin
         return {1'b0, 4'(c - "a" + 8'd10)};
      end
      return HEX_BASE;
   endfunction

   // Idle rate for a stretch of the run; zero often, so that long runs
   // without any bubble occur too.
   function automatic int pick_rate();
      case ($urandom_range(0, 4))
         0, 1: begin
            return 0;
         end
         2: begin
            return 10;
         end
         3: begin
            return 40;
         end
         default: begin
            return 80;
         end
      endcase
   endfunction

   // Works out what one accepted byte produces and queues it if anything.
   // The decoder emits at most one result per byte.
   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [4:0] hi;
      logic [4:0] lo;
      logic       emit;
      result_type r;
      emit = 1'b0;
      r.out_byte = 8'h00;
      r.error_code = ERR_NONE;
      r.string_done = 1'b0;
      // After an error the rest of the string is swallowed, including its
      // final byte, which only resets the string state.
      if (dropping) begin
         if (last) begin
            esc_phase = PH_IDLE;
            in_query = 1'b0;
            dropping = 1'b0;
         end
         return;
      end
      case (esc_phase)
         PH_PERCENT: begin
            // First digit is only held; it is not checked until the second.
            high_digit = b;
            esc_phase = PH_HIGH;
            if (last) begin
               r.error_code = ERR_MISSING;
               emit = 1'b1;
            end
         end
         PH_HIGH: begin
            hi = digit_weight(high_digit);
            lo = digit_weight(b);
            esc_phase = PH_IDLE;
            if (hi[4] || lo[4]) begin
               r.error_code = ERR_BAD_DIGIT;
            end else begin
               r.out_byte = {hi[3:0], lo[3:0]};
            end
            emit = 1'b1;
         end
         default: begin
            // Only a raw '?' opens the query part; an escaped one does not
            // come through here.
            esc_phase = PH_IDLE;
            if (b == CH_QUERY) begin
               in_query = 1'b1;
            end
            if (in_query && cfg_plus_space && b == CH_PLUS) begin
               r.out_byte = CH_SPACE;
               emit = 1'b1;
            end else if (b == CH_PERCENT) begin
               esc_phase = PH_PERCENT;
               if (last) begin
                  r.error_code = ERR_MISSING;
                  emit = 1'b1;
               end
            end else begin
               r.out_byte = b;
               emit = 1'b1;
            end
         end
      endcase
      if (last) begin
         esc_phase = PH_IDLE;
         in_query = 1'b0;
         dropping = 1'b0;
      end else if (r.error_code != ERR_NONE) begin
         dropping = 1'b1;
         esc_phase = PH_IDLE;
      end
      if (emit) begin
         r.string_done = last || (r.error_code != ERR_NONE);
         want_q.push_back(r);
      end
   endtask

   task automatic report_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
   endtask

   task automatic queue_job(input job_kind_type kind, input logic [7:0] data,
                            input logic last);
      job_type j;
      j.kind = kind;
      j.data = data;
      j.last = last;
      job_q.push_back(j);
      if (kind == JOB_BYTE) begin
         bytes_queued++;
      end
   endtask

   // Queues the characters of s; the final one closes the string if ends is set.
   task automatic queue_text(input string s, input logic ends);
      for (int i = 0; i < s.len(); i++) begin
         queue_job(JOB_BYTE, s[i], ends && i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] hex_char();
      logic [3:0] v;
      v = 4'($urandom_range(0, 15));
      if (v < 4'd10) begin
         return "0" + 8'(v);
      end
      return ($urandom_range(0, 1) ? "A" : "a") + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] pool[$];
      if ($urandom_range(0, 2) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      pool = '{"a", "z", "Q", "7", "/", "=", "&", "-", ".", "_", "g", "0"};
      return pool[$urandom_range(0, pool.size() - 1)];
   endfunction

   // One string, mostly made of sane URI pieces with random content: plain
   // characters, well-formed escapes, '?' and '+'. A minority of pieces are
   // broken escapes or arbitrary bytes, and some strings end mid escape.
   task automatic queue_random_string();
      logic [7:0] text[$];
      int         tokens;
      int         roll;
      tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      repeat (tokens) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            text.push_back(plain_char());
         end else if (roll < 55) begin
            text.push_back(CH_PERCENT);
            text.push_back(hex_char());
            text.push_back(hex_char());
         end else if (roll < 63) begin
            text.push_back(CH_QUERY);
         end else if (roll < 75) begin
            text.push_back(CH_PLUS);
         end else if (roll < 82) begin
            // Escape with one digit that is most likely not hex.
            text.push_back(CH_PERCENT);
            if ($urandom_range(0, 1)) begin
               text.push_back(8'($urandom_range(0, 255)));
               text.push_back(hex_char());
            end else begin
               text.push_back(hex_char());
               text.push_back(8'($urandom_range(0, 255)));
            end
         end else if (roll < 88) begin
            // Escaped forms of the characters the decoder treats specially.
            text.push_back(CH_PERCENT);
            case ($urandom_range(0, 3))
               0: begin
                  text.push_back("3");
                  text.push_back("F");
               end
               1: begin
                  text.push_back("3");
                  text.push_back("f");
               end
               2: begin
                  text.push_back("2");
                  text.push_back("B");
               end
               default: begin
                  text.push_back("2");
                  text.push_back("5");
               end
            endcase
         end else begin
            text.push_back(8'($urandom_range(0, 255)));
         end
      end
      case ($urandom_range(0, 15))
         0: begin
            text.push_back(CH_PERCENT);
         end
         1: begin
            text.push_back(CH_PERCENT);
            text.push_back(hex_char());
         end
         default: begin
         end
      endcase
      foreach (text[i]) begin
         queue_job(JOB_BYTE, text[i], i == text.size() - 1);
      end
   endtask

   // Driver. It pulls jobs off job_q and presents them on the req or csr
   // channel, holding each until its transfer. Register writes and holds
   // only go out once the block has gone quiet.
   always @(posedge clock) begin
      job_type    job;
      logic       nxt_req_valid;
      logic [7:0] nxt_byte;
      logic       nxt_last;
      logic       nxt_csr_valid;
      logic       nxt_csr_data;
      nxt_req_valid = req_valid;
      nxt_byte = req_in_byte;
      nxt_last = req_last_byte;
      nxt_csr_valid = csr_valid;
      nxt_csr_data = csr_plus_as_space;
      if (reset) begin
         nxt_req_valid = 1'b0;
         nxt_csr_valid = 1'b0;
         quiet = 0;
      end else begin
         if (req_valid && req_ready) begin
            nxt_req_valid = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            nxt_csr_valid = 1'b0;
         end
         if (results_pending == 0 && !req_valid && !csr_valid) begin
            quiet++;
         end else begin
            quiet = 0;
         end
         if ($urandom_range(0, 199) == 0) begin
            gap_pct = pick_rate();
         end
         if (!nxt_req_valid && !nxt_csr_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (job_q.size() != 0) begin
               job = job_q[0];
               case (job.kind)
                  JOB_BYTE: begin
                     void'(job_q.pop_front());
                     nxt_req_valid = 1'b1;
                     nxt_byte = job.data;
                     nxt_last = job.last;
                     // The bubble, if any, follows this byte's transfer.
                     if (!calm_tail && $urandom_range(0, 99) < gap_pct) begin
                        gap_left = $urandom_range(1, 14);
                     end
                  end
                  JOB_CSR: begin
                     if (quiet >= SETTLE) begin
                        void'(job_q.pop_front());
                        nxt_csr_valid = 1'b1;
                        nxt_csr_data = job.data[0];
                     end
                  end
                  default: begin
                     if (quiet >= SETTLE) begin
                        void'(job_q.pop_front());
                     end
                  end
               endcase
            end
         end
      end
      req_valid <= nxt_req_valid;
      req_in_byte <= nxt_byte;
      req_last_byte <= nxt_last;
      csr_valid <= nxt_csr_valid;
      csr_plus_as_space <= nxt_csr_data;
      calm_tail <= job_q.size() < TAIL_JOBS;
      stimulus_done <= !reset && job_q.size() == 0 && !nxt_req_valid && !nxt_csr_valid;
   end

   // Result sink: random stall bursts, with no new burst once the tail of the run starts.
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) begin
         stall_pct = pick_rate();
      end
      if (stall_left == 0 && !calm_tail && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor. Every transfer seen at this edge updates the prediction or is
   // checked against the oldest result still owed.
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            cfg_plus_space = csr_plus_as_space;
         end
         if (req_valid && req_ready) begin
            decode_byte(req_in_byte, req_last_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (want_q.size() == 0) begin
               mismatches++;
               $display("%0t: result with none expected, actual %h/%0d/%0b", $time,
                        rsp_out_byte, rsp_error_code, rsp_string_done);
            end else begin
               want = want_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  report_field("out_byte", want.out_byte, rsp_out_byte);
               end
               if (rsp_error_code !== want.error_code) begin
                  report_field("error_code", want.error_code, rsp_error_code);
               end
               if (rsp_string_done !== want.string_done) begin
                  report_field("string_done", want.string_done, rsp_string_done);
               end
            end
         end
      end
      results_pending <= want_q.size();
   end

   // Watchdog. The limit is several times the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** percent_decoder: FAILED **");
         $finish;
      end
   end

   initial begin
      int directed_bytes;
      int target;
      // Directed strings, first with the register at its reset value of 0:
      // the byte extremes with '+' before and after '?', an escape mixing
      // upper and lower case, strings that end after '%' and after the
      // first digit, and a non-hex first digit followed by a dropped tail.
      queue_job(JOB_BYTE, 8'h00, 1'b0);
      queue_text("+?+", 1'b0);
      queue_job(JOB_BYTE, 8'hFF, 1'b1);
      queue_text("%Fa", 1'b1);
      queue_text("%", 1'b1);
      queue_text("%3", 1'b1);
      queue_text("%G1z", 1'b1);
      // With plus-as-space on: an escaped '?' must not open the query part,
      // while a raw one does. Then a bad second digit on the final byte.
      queue_job(JOB_CSR, 8'h01, 1'b0);
      queue_text("%3F+?+", 1'b1);
      queue_text("%1g", 1'b1);
      directed_bytes = bytes_queued;

      // Random phases alternate the register, with an occasional hold in
      // which the sender waits for every outstanding result.
      for (int p = 0; p < RAND_PHASES; p++) begin
         queue_job(JOB_CSR, 8'(p % 2), 1'b0);
         target = directed_bytes + (p + 1) * (TOTAL_BYTES - directed_bytes) / RAND_PHASES;
         while (bytes_queued < target) begin
            queue_random_string();
            if ($urandom_range(0, 59) == 0) begin
               queue_job(JOB_HOLD, 8'h00, 1'b0);
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (stimulus_done && results_pending == 0);
      // Sampling on the falling edge keeps the final read clear of the
      // monitor's updates. The extra cycles also flush trailing bytes that
      // produce nothing and catch any stray result.
      repeat (TAIL_CYCLES) @(negedge clock);
      if (want_q.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected results never arrived", $time, want_q.size());
      end
      if (mismatches == 0) begin
         $display("** percent_decoder: PASSED **");
      end else begin
         $display("** percent_decoder: FAILED **");
      end
      $finish;
   end

endmodule
